[design/assert_macros.svh]
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is high
`define GSST_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define GSST_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/gsst_pkg.sv]
// ----------------------------------------------------------------------------
// gsst_pkg
// types and codes shared by the growable sum tree modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package gsst_pkg;

   // widest element count over the supported capacity range
   localparam int MAX_CW = 21;

   typedef enum logic [1:0] {
      KIND_APPEND = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_UPDATE = 2'd2,
      KIND_QUERY  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;
      logic [9:0]  index;
      logic [10:0] range_end;
   } req_word_type;

   typedef struct packed {
      logic [31:0] sum;
      logic [10:0] count;
      logic [1:0]  status;
   } rsp_word_type;

   // classified request handed from front to back
   typedef struct packed {
      kind_type          kind;
      logic              ok;
      status_type        status;
      logic [MAX_CW-1:0] count_before;
      logic [MAX_CW-1:0] count_after;
      logic [31:0]       value;
      logic [9:0]        index;
      logic [10:0]       range_end;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_WRITE,
      B_READ,
      B_WAIT,
      B_QSTEP,
      B_QWAIT,
      B_DONE
   } back_state_type;

endpackage

[design/gsst_front.sv]
// ----------------------------------------------------------------------------
// gsst_front
// accepts requests, checks them against the element count, keeps the count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gsst_front #(
   parameter int CAPACITY = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  gsst_pkg::req_word_type    req_word,
   input  gsst_pkg::queue_status_type q_status,
   output logic                      busy,
   output logic                      push,
   output gsst_pkg::entry_type       push_entry
);
   import gsst_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CW > 11) ? CW : 11;

   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] cnt_x, idx_x, end_x;
   logic          ok;
   status_type    status;

   assign busy  = q_status.full;
   assign push  = start && !busy;
   assign cnt_x = IW'(count_ff);
   assign idx_x = IW'(req_word.index);
   assign end_x = IW'(req_word.range_end);

   // classify the request
   always_comb begin
      ok       = 1'b1;
      status   = STATUS_OK;
      count_in = count_ff;
      case (kind_type'(req_word.kind))
         KIND_APPEND: begin
            if (cnt_x >= IW'(CAPACITY)) begin
               ok     = 1'b0;
               status = STATUS_FULL;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         KIND_REMOVE: begin
            if (count_ff == '0) begin
               ok     = 1'b0;
               status = STATUS_RANGE;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         KIND_UPDATE: begin
            if (idx_x >= cnt_x) begin
               ok     = 1'b0;
               status = STATUS_RANGE;
            end
         end
         default: begin
            if (idx_x > end_x || end_x > cnt_x) begin
               ok     = 1'b0;
               status = STATUS_RANGE;
            end
         end
      endcase
   end

   always_comb begin
      push_entry.kind         = kind_type'(req_word.kind);
      push_entry.ok           = ok;
      push_entry.status       = status;
      push_entry.count_before = MAX_CW'(count_ff);
      push_entry.count_after  = MAX_CW'(count_in);
      push_entry.value        = req_word.value;
      push_entry.index        = req_word.index;
      push_entry.range_end    = req_word.range_end;
   end

   // element count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (push) begin
         count_ff <= count_in;
      end
   end

endmodule

[design/gsst_queue.sv]
// ----------------------------------------------------------------------------
// gsst_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gsst_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  gsst_pkg::entry_type        push_entry,
   input  logic                       pop,
   output gsst_pkg::entry_type        pop_entry,
   output gsst_pkg::queue_status_type q_status
);
   import gsst_pkg::*;

   entry_type  slot_ff [0:1];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff, fill_in;

   assign pop_entry      = slot_ff[rd_ptr_ff];
   assign q_status.full  = (fill_ff == 2'd2);
   assign q_status.empty = (fill_ff == 2'd0);

   always_comb begin
      fill_in = fill_ff;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         fill_ff <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

[design/gsst_back.sv]
// ----------------------------------------------------------------------------
// gsst_back
// walks stored levels for append, update, query; sends one word per request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gsst_back #(
   parameter int CAPACITY   = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gsst_pkg::entry_type        pop_entry,
   input  gsst_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       rsp_strobe,
   output gsst_pkg::rsp_word_type     rsp_word
);
   import gsst_pkg::*;

   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int IW    = (CW > 11) ? CW : 11;
   localparam int DEPTH = 2 * CAPACITY;
   localparam int AW    = $clog2(DEPTH);

   back_state_type  state_ff, state_in;
   entry_type       ent_ff, ent_in;
   logic [IW-1:0]   idx_ff, idx_in, rgt_ff, rgt_in, csh_ff, csh_in;
   logic [CW-1:0]   lsz_ff, lsz_in;
   logic [AW-1:0]   base_ff, base_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] mem [0:DEPTH-1];
   logic [DATA_WIDTH-1:0] rdata_ff;
   logic [AW-1:0]   addr;
   logic            we;
   logic            climb;

   // keep climbing while the pair above still exists
   assign climb = (ent_ff.kind == KIND_APPEND) ? idx_ff[0]
                                               : ((idx_ff | IW'(1)) < csh_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               if (!pop_entry.ok || pop_entry.kind == KIND_REMOVE) state_in = B_DONE;
               else if (pop_entry.kind == KIND_QUERY)              state_in = B_QSTEP;
               else                                                state_in = B_WRITE;
            end
         end
         B_WRITE: state_in = climb ? B_READ : B_DONE;
         B_READ:  state_in = B_WAIT;
         B_WAIT:  state_in = B_WRITE;
         B_QSTEP: begin
            if (idx_ff >= rgt_ff)               state_in = B_DONE;
            else if (idx_ff[0] || rgt_ff[0])    state_in = B_QWAIT;
            else                                state_in = B_QSTEP;
         end
         B_QWAIT: state_in = B_QSTEP;
         B_DONE:  state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // datapath and memory access
   always_comb begin
      ent_in  = ent_ff;
      idx_in  = idx_ff;
      rgt_in  = rgt_ff;
      csh_in  = csh_ff;
      lsz_in  = lsz_ff;
      base_in = base_ff;
      acc_in  = acc_ff;
      addr    = base_ff + AW'(idx_ff);
      we      = 1'b0;
      pop     = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               pop     = 1'b1;
               ent_in  = pop_entry;
               base_in = '0;
               lsz_in  = CW'(CAPACITY);
               acc_in  = DATA_WIDTH'(pop_entry.value);
               csh_in  = IW'(pop_entry.count_before);
               if (pop_entry.kind == KIND_APPEND) idx_in = IW'(pop_entry.count_before);
               else                               idx_in = IW'(pop_entry.index);
               rgt_in = IW'(pop_entry.range_end);
               if (pop_entry.kind == KIND_QUERY) acc_in = '0;
            end
         end
         B_WRITE: begin
            we = 1'b1;
         end
         B_READ: begin
            addr = base_ff + AW'(idx_ff ^ IW'(1));
         end
         B_WAIT: begin
            acc_in  = acc_ff + rdata_ff;
            idx_in  = idx_ff >> 1;
            csh_in  = csh_ff >> 1;
            base_in = base_ff + AW'(lsz_ff);
            lsz_in  = lsz_ff >> 1;
         end
         B_QSTEP: begin
            if (idx_ff < rgt_ff) begin
               if (idx_ff[0]) begin
                  idx_in = idx_ff + IW'(1);
               end else if (rgt_ff[0]) begin
                  addr   = base_ff + AW'(rgt_ff - IW'(1));
                  rgt_in = rgt_ff - IW'(1);
               end else begin
                  idx_in  = idx_ff >> 1;
                  rgt_in  = rgt_ff >> 1;
                  base_in = base_ff + AW'(lsz_ff);
                  lsz_in  = lsz_ff >> 1;
               end
            end
         end
         B_QWAIT: begin
            acc_in = acc_ff + rdata_ff;
         end
         default: begin
         end
      endcase
   end

   // result word
   always_comb begin
      rsp_strobe      = (state_ff == B_DONE);
      rsp_word.count  = 11'(ent_ff.count_after);
      rsp_word.status = ent_ff.status;
      rsp_word.sum    = (ent_ff.kind == KIND_QUERY && ent_ff.ok) ? 32'(acc_ff) : 32'd0;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      idx_ff  <= idx_in;
      rgt_ff  <= rgt_in;
      csh_ff  <= csh_in;
      lsz_ff  <= lsz_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
   end

   // level store, single port
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= acc_ff;
      rdata_ff <= mem[addr];
   end

endmodule

[design/growable_sum_segment_tree.sv]
// from start to rsp_strobe, back end idle: the request goes into the queue, the back end pops
// it in its idle state and ends in its done state; remove and rejected requests go straight
// to done, append and update walk the levels through write, read and wait, a query through
// qstep and qwait, over the single-port level store. The back end holds one request; the
// two-entry queue lets the sender run ahead. reset: synchronous, clears count, queue and
// sequencer; level store not cleared. rsp_strobe cannot be stalled by the receiver
// ----------------------------------------------------------------------------
// growable_sum_segment_tree
// range-sum tree over a growable array with append, remove, update and query
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module growable_sum_segment_tree #(
   parameter int CAPACITY   = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  gsst_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output gsst_pkg::rsp_word_type rsp_word
);
   import gsst_pkg::*;

   logic             push, pop;
   entry_type        push_entry, pop_entry;
   queue_status_type q_status;

   gsst_front #(.CAPACITY(CAPACITY)) u_front (
      .clock(clock), .reset(reset), .start(start), .req_word(req_word),
      .q_status(q_status), .busy(busy), .push(push), .push_entry(push_entry)
   );

   gsst_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_entry(push_entry),
      .pop(pop), .pop_entry(pop_entry), .q_status(q_status)
   );

   gsst_back #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_back (
      .clock(clock), .reset(reset), .pop_entry(pop_entry), .q_status(q_status),
      .pop(pop), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

endmodule

[design/gsst_checker.sv]
// ----------------------------------------------------------------------------
// gsst_checker
// port-level checks on the growable sum tree
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gsst_checker #(
   parameter int CAPACITY = 1024
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input gsst_pkg::req_word_type req_word,
   input logic                   rsp_strobe,
   input gsst_pkg::rsp_word_type rsp_word
);
   import gsst_pkg::*;

   // no word comes out right after reset
   `GSST_ASSERT_ALWAYS(a_quiet_after_reset, clock, $past(reset) |-> !rsp_strobe, "word after reset")

   // rejected requests carry no sum
   `GSST_ASSERT(a_reject_zero_sum, clock, reset, (rsp_strobe && rsp_word.status != STATUS_OK) |-> (rsp_word.sum == 32'd0), "sum on rejected request")

   // count stays within capacity
   `GSST_ASSERT(a_count_bound, clock, reset, rsp_strobe |-> (32'(rsp_word.count) <= 32'(CAPACITY)), "count above capacity")

   // each response word is a single-cycle strobe
   `GSST_ASSERT(a_single_strobe, clock, reset, rsp_strobe |=> !rsp_strobe, "strobe held two cycles")

   // an accepted request word is fully defined
   `GSST_ASSERT(a_req_known, clock, reset, (start && !busy) |-> !$isunknown(req_word), "unknown request word")

endmodule

bind growable_sum_segment_tree gsst_checker #(.CAPACITY(CAPACITY)) u_gsst_checker (.*);
